// ----- rtl/ggs_pkg.sv -----
// Shared constants, codes and job types of the grid gradient stencil.
package ggs_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COL_BITS    = $clog2(DEF_MAX_WIDTH);
    localparam int DEF_ROW_BITS    = $clog2(DEF_MAX_HEIGHT);

    // Configuration port
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_BITS-1:0] GRID_SIZE_RESET = 11'd1024;
    localparam int MIN_GRID_SIZE  = 2;

    // Result format
    localparam int GRAD_BITS  = 18;
    localparam int GRAD_LIMIT = 131070;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        JOB_SAMPLE = 1'b0,
        JOB_FLUSH  = 1'b1
    } t_job_kind;

    // Classification of one job, made by the front, used by the back
    typedef struct packed {
        t_job_kind kind;
        logic      emit;       // job produces a gradient word
        logic      at_start;   // first column
        logic      at_end;     // last column
        logic      first_row;  // point lies on the top row
        logic      done;       // last point of the field
    } t_job_ctl;

endpackage

// ----- rtl/ggs_in_if.sv -----
// Input channel: command and sample word with valid/ready handshake.
interface ggs_in_if #(
    parameter int SAMPLE_BITS = ggs_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, cmd, sample_value, input ready);
    modport sink   (input valid, cmd, sample_value, output ready);
endinterface

// ----- rtl/ggs_out_if.sv -----
// Output channel: gradient word with valid/ready handshake.
interface ggs_out_if #(
    parameter int COL_BITS = ggs_pkg::DEF_COL_BITS,
    parameter int ROW_BITS = ggs_pkg::DEF_ROW_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic signed [ggs_pkg::GRAD_BITS-1:0] grad_x;
    logic signed [ggs_pkg::GRAD_BITS-1:0] grad_y;
    logic        [COL_BITS-1:0]           point_col;
    logic        [ROW_BITS-1:0]           point_row;
    logic                                 frame_done;

    modport source (output valid, grad_x, grad_y, point_col, point_row, frame_done,
                    input ready);
    modport sink   (input valid, grad_x, grad_y, point_col, point_row, frame_done,
                    output ready);
endinterface

// ----- rtl/ggs_front.sv -----
// Front end: size registers, raster and flush counters, job classification.
module ggs_front #(
    parameter int MAX_WIDTH   = ggs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ggs_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ggs_pkg::DEF_SAMPLE_BITS,
    parameter int COL_BITS    = $clog2(MAX_WIDTH),
    parameter int ROW_BITS    = $clog2(MAX_HEIGHT)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ggs_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [ggs_pkg::CFG_BITS-1:0]           i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    output logic                                   o_push_valid,
    input  logic                                   i_push_ready,
    output ggs_pkg::t_job_ctl                      o_ctl,
    output logic [COL_BITS-1:0]                    o_col,
    output logic [ROW_BITS-1:0]                    o_row,
    output logic signed [SAMPLE_BITS-1:0]          o_sample
);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd;

    localparam int CW = ($clog2(MAX_WIDTH + 1) > ggs_pkg::CFG_BITS) ?
                        $clog2(MAX_WIDTH + 1) : ggs_pkg::CFG_BITS;
    localparam int CH = ($clog2(MAX_HEIGHT + 1) > ggs_pkg::CFG_BITS) ?
                        $clog2(MAX_HEIGHT + 1) : ggs_pkg::CFG_BITS;

    logic [ggs_pkg::CFG_BITS-1:0] r_grid_width;
    logic [ggs_pkg::CFG_BITS-1:0] r_grid_height;
    logic [COL_BITS-1:0]          r_col, n_col;
    logic [ROW_BITS-1:0]          r_row, n_row;
    logic                         r_flush, n_flush;
    logic [COL_BITS-1:0]          r_flush_col, n_flush_col;

    logic [CW-1:0]       width_ext;
    logic [CH-1:0]       height_ext;
    logic [COL_BITS-1:0] last_col;
    logic [ROW_BITS-1:0] last_row;
    logic                in_fire;

    // Clamp the size registers into the supported range
    always_comb begin
        width_ext  = CW'(r_grid_width);
        height_ext = CH'(r_grid_height);
        if (width_ext < CW'(ggs_pkg::MIN_GRID_SIZE)) begin
            last_col = COL_BITS'(ggs_pkg::MIN_GRID_SIZE - 1);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            last_col = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_BITS'(width_ext - CW'(1));
        end
        if (height_ext < CH'(ggs_pkg::MIN_GRID_SIZE)) begin
            last_row = ROW_BITS'(ggs_pkg::MIN_GRID_SIZE - 1);
        end else if (height_ext > CH'(MAX_HEIGHT)) begin
            last_row = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            last_row = ROW_BITS'(height_ext - CH'(1));
        end
    end

    assign o_ready = i_push_ready;
    assign in_fire = i_valid && o_ready;

    // Classify the accepted word and advance the raster position
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_flush      = r_flush;
        n_flush_col  = r_flush_col;
        o_push_valid = 1'b0;
        o_ctl        = '0;
        o_col        = r_col;
        o_row        = r_row - ROW_BITS'(1);
        o_sample     = i_sample;
        if (in_fire) begin
            if (t_cmd'(i_cmd) == CMD_FLUSH) begin
                // flush tick: emit one point of the last row
                if (r_flush) begin
                    o_push_valid   = 1'b1;
                    o_ctl.kind     = ggs_pkg::JOB_FLUSH;
                    o_ctl.emit     = 1'b1;
                    o_ctl.at_start = (r_flush_col == '0);
                    o_ctl.at_end   = (r_flush_col == last_col);
                    o_ctl.done     = (r_flush_col == last_col);
                    o_col          = r_flush_col;
                    o_row          = last_row;
                    if (r_flush_col == last_col) begin
                        n_flush     = 1'b0;
                        n_flush_col = '0;
                    end else begin
                        n_flush_col = r_flush_col + COL_BITS'(1);
                    end
                end
            end else if (!r_flush) begin
                // field sample: update line buffers, emit the row above
                o_push_valid    = 1'b1;
                o_ctl.kind      = ggs_pkg::JOB_SAMPLE;
                o_ctl.emit      = (r_row != '0);
                o_ctl.at_start  = (r_col == '0);
                o_ctl.at_end    = (r_col == last_col);
                o_ctl.first_row = (r_row == ROW_BITS'(1));
                if (r_col == last_col) begin
                    n_col = '0;
                    if (r_row == last_row) begin
                        n_row       = '0;
                        n_flush     = 1'b1;
                        n_flush_col = '0;
                    end else begin
                        n_row = r_row + ROW_BITS'(1);
                    end
                end else begin
                    n_col = r_col + COL_BITS'(1);
                end
            end
        end
    end

    // Hold configuration and counters; a register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= ggs_pkg::GRID_SIZE_RESET;
            r_grid_height <= ggs_pkg::GRID_SIZE_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_flush       <= 1'b0;
            r_flush_col   <= '0;
        end else if (i_cfg_we) begin
            case (ggs_pkg::t_cfg_reg'(i_cfg_index))
                ggs_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                ggs_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
            r_col       <= '0;
            r_row       <= '0;
            r_flush     <= 1'b0;
            r_flush_col <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_flush     <= n_flush;
            r_flush_col <= n_flush_col;
        end
    end

    a_flush_job_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push_valid && o_ctl.kind == ggs_pkg::JOB_FLUSH) |-> r_flush)
        else $error("flush job issued outside the flush phase");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0 && r_row == '0 && !r_flush && r_flush_col == '0))
        else $error("register write did not restart the frame");

endmodule

// ----- rtl/ggs_queue.sv -----
// Small job queue that decouples the front end from the back end.
module ggs_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = ggs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             push;
    logic             pop;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_push_ready = (r_count != CNTW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("queue fill count did not follow a push");

endmodule

// ----- rtl/ggs_back.sv -----
// Back end: line-buffer memories, stencil arithmetic and output register.
module ggs_back #(
    parameter int MAX_WIDTH   = ggs_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = ggs_pkg::DEF_SAMPLE_BITS,
    parameter int COL_BITS    = $clog2(MAX_WIDTH),
    parameter int ROW_BITS    = ggs_pkg::DEF_ROW_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_job_valid,
    output logic                                  o_job_ready,
    input  ggs_pkg::t_job_ctl                     i_ctl,
    input  logic [COL_BITS-1:0]                   i_col,
    input  logic [ROW_BITS-1:0]                   i_row,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ggs_pkg::GRAD_BITS-1:0]  o_grad_x,
    output logic signed [ggs_pkg::GRAD_BITS-1:0]  o_grad_y,
    output logic [COL_BITS-1:0]                   o_col,
    output logic [ROW_BITS-1:0]                   o_row,
    output logic                                  o_done
);

    localparam int CW = (SAMPLE_BITS + 2 > ggs_pkg::GRAD_BITS + 1) ?
                        SAMPLE_BITS + 2 : ggs_pkg::GRAD_BITS + 1;
    localparam logic signed [CW-1:0] LIM = CW'(ggs_pkg::GRAD_LIMIT);

    // Line buffers: row above and the row above that, one entry per column
    logic signed [SAMPLE_BITS-1:0] r_prev_mem  [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] r_older_mem [MAX_WIDTH];

    // Stage A: job plus registered memory reads
    logic                          r_a_valid;
    ggs_pkg::t_job_ctl             r_a_ctl;
    logic [COL_BITS-1:0]           r_a_col;
    logic [ROW_BITS-1:0]           r_a_row;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic signed [SAMPLE_BITS-1:0] r_mid;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic signed [SAMPLE_BITS-1:0] r_older;
    logic signed [SAMPLE_BITS-1:0] r_left;

    // Output register
    logic                                 r_o_valid;
    logic signed [ggs_pkg::GRAD_BITS-1:0] r_o_gx;
    logic signed [ggs_pkg::GRAD_BITS-1:0] r_o_gy;
    logic [COL_BITS-1:0]                  r_o_col;
    logic [ROW_BITS-1:0]                  r_o_row;
    logic                                 r_o_done;

    logic                          out_free;
    logic                          a_adv;
    logic                          pop;
    logic                          wr_en;
    logic [COL_BITS-1:0]           right_addr;
    logic signed [SAMPLE_BITS-1:0] xa, xb, ya, yb;
    logic                          dbl_x, dbl_y;
    logic signed [SAMPLE_BITS:0]   dx, dy;
    logic signed [ggs_pkg::GRAD_BITS-1:0] gx, gy;

    // Widen a difference, double it for one-sided stencils, saturate
    function automatic logic signed [ggs_pkg::GRAD_BITS-1:0] scale_sat(
        input logic signed [SAMPLE_BITS:0] d,
        input logic                        dbl
    );
        logic signed [CW-1:0] v;
        v = {{(CW - SAMPLE_BITS - 1){d[SAMPLE_BITS]}}, d};
        if (dbl) begin
            v = v <<< 1;
        end
        if (v > LIM) begin
            v = LIM;
        end else if (v < -LIM) begin
            v = -LIM;
        end
        return v[ggs_pkg::GRAD_BITS-1:0];
    endfunction

    // Handshake between queue, stage A and output register
    assign out_free    = !r_o_valid || i_ready;
    assign a_adv       = r_a_valid && (out_free || !r_a_ctl.emit);
    assign o_job_ready = !r_a_valid || a_adv;
    assign pop         = i_job_valid && o_job_ready;
    assign wr_en       = a_adv && (r_a_ctl.kind == ggs_pkg::JOB_SAMPLE);
    assign right_addr  = i_col + COL_BITS'(1);

    // Write back the new sample and shift the old one down a row
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_prev_mem[r_a_col]  <= r_a_sample;
            r_older_mem[r_a_col] <= r_mid;
        end
    end

    // Read the stencil neighbors; forward a write to the same column
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mid      <= (wr_en && r_a_col == i_col) ? r_a_sample : r_prev_mem[i_col];
            r_right    <= (wr_en && r_a_col == right_addr) ? r_a_sample
                                                            : r_prev_mem[right_addr];
            r_older    <= (wr_en && r_a_col == i_col) ? r_mid : r_older_mem[i_col];
            r_a_ctl    <= i_ctl;
            r_a_col    <= i_col;
            r_a_row    <= i_row;
            r_a_sample <= i_sample;
        end
        if (a_adv) begin
            r_left <= r_mid;
        end
    end

    // Pick stencil operands
    always_comb begin
        xa    = r_right;
        xb    = r_left;
        dbl_x = 1'b0;
        if (r_a_ctl.at_start) begin
            xb    = r_mid;
            dbl_x = 1'b1;
        end else if (r_a_ctl.at_end) begin
            xa    = r_mid;
            dbl_x = 1'b1;
        end
        if (r_a_ctl.kind == ggs_pkg::JOB_FLUSH) begin
            ya    = r_mid;
            yb    = r_older;
            dbl_y = 1'b1;
        end else if (r_a_ctl.first_row) begin
            ya    = r_a_sample;
            yb    = r_mid;
            dbl_y = 1'b1;
        end else begin
            ya    = r_a_sample;
            yb    = r_older;
            dbl_y = 1'b0;
        end
        dx = $signed({xa[SAMPLE_BITS-1], xa}) - $signed({xb[SAMPLE_BITS-1], xb});
        dy = $signed({ya[SAMPLE_BITS-1], ya}) - $signed({yb[SAMPLE_BITS-1], yb});
        gx = scale_sat(dx, dbl_x);
        gy = scale_sat(dy, dbl_y);
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_ctl.emit) begin
            r_o_gx   <= gx;
            r_o_gy   <= gy;
            r_o_col  <= r_a_col;
            r_o_row  <= r_a_row;
            r_o_done <= r_a_ctl.done;
        end
    end

    // Hold valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv && r_a_ctl.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_grad_x = r_o_gx;
    assign o_grad_y = r_o_gy;
    assign o_col    = r_o_col;
    assign o_row    = r_o_row;
    assign o_done   = r_o_done;

    a_done_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_ctl.done) |->
            (r_a_ctl.kind == ggs_pkg::JOB_FLUSH && r_a_ctl.emit && r_a_ctl.at_end))
        else $error("frame end marked on a job that is not the last flush point");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> (r_a_valid && $stable(r_a_col) && $stable(r_mid)))
        else $error("stalled stencil stage lost its job");

endmodule

// ----- rtl/grid_gradient_stencil.sv -----
// Top level of the streaming 2-D gradient stencil.
// Samples of a grid_width x grid_height field enter in raster order, one word
// per clock while the queue has room; each sample word gives the x/y gradient
// of the point one row above it, so the first row gives nothing and, once the
// field is complete, grid_width flush words give the last row (frame_done
// marks its last point). Sustained rate is one word per cycle on both sides
// unless the output stalls; each result passes the job queue, the line-buffer
// read and the output register. Two line buffers of MAX_WIDTH samples hold
// the two rows above; they are not cleared at reset. Gradients carry one
// more fractional bit than the samples and saturate at +/-131070. Write the
// size registers only while the block is idle; any write restarts the frame.
module grid_gradient_stencil #(
    parameter int MAX_WIDTH   = ggs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ggs_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ggs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ggs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ggs_pkg::CFG_BITS-1:0]       i_cfg_data,
    ggs_in_if.sink                             i_sample_ch,
    ggs_out_if.source                          o_grad_ch
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int QW = $bits(ggs_pkg::t_job_ctl) + COL_BITS + ROW_BITS + SAMPLE_BITS;

    logic                          f_valid;
    logic                          f_ready;
    ggs_pkg::t_job_ctl             f_ctl;
    logic [COL_BITS-1:0]           f_col;
    logic [ROW_BITS-1:0]           f_row;
    logic signed [SAMPLE_BITS-1:0] f_sample;

    logic                          q_valid;
    logic                          q_ready;
    logic [QW-1:0]                 q_data;
    ggs_pkg::t_job_ctl             q_ctl;
    logic [COL_BITS-1:0]           q_col;
    logic [ROW_BITS-1:0]           q_row;
    logic signed [SAMPLE_BITS-1:0] q_sample;

    ggs_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_BITS    (COL_BITS),
        .ROW_BITS    (ROW_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_sample_ch.valid),
        .o_ready      (i_sample_ch.ready),
        .i_cmd        (i_sample_ch.cmd),
        .i_sample     (i_sample_ch.sample_value),
        .o_push_valid (f_valid),
        .i_push_ready (f_ready),
        .o_ctl        (f_ctl),
        .o_col        (f_col),
        .o_row        (f_row),
        .o_sample     (f_sample)
    );

    ggs_queue #(
        .WIDTH (QW),
        .DEPTH (ggs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_ctl, f_col, f_row, f_sample}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    // Split the queued word into its job fields
    assign {q_ctl, q_col, q_row, q_sample} = q_data;

    ggs_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_BITS    (COL_BITS),
        .ROW_BITS    (ROW_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_ctl       (q_ctl),
        .i_col       (q_col),
        .i_row       (q_row),
        .i_sample    (q_sample),
        .o_valid     (o_grad_ch.valid),
        .i_ready     (o_grad_ch.ready),
        .o_grad_x    (o_grad_ch.grad_x),
        .o_grad_y    (o_grad_ch.grad_y),
        .o_col       (o_grad_ch.point_col),
        .o_row       (o_grad_ch.point_row),
        .o_done      (o_grad_ch.frame_done)
    );

endmodule

// ----- verif/grid_gradient_stencil_tb.sv -----
// Self-checking testbench of grid_gradient_stencil: random and directed fields, predicted gradients.
module grid_gradient_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int SETTLE_CYC  = 6;
    localparam int DRAIN_LIMIT = 4000;
    localparam int GRAD_SAT    = 131070;

    typedef struct {
        logic signed [ggs_pkg::GRAD_BITS-1:0] gx;
        logic signed [ggs_pkg::GRAD_BITS-1:0] gy;
        logic [9:0]                           col;
        logic [9:0]                           row;
        logic                                 done;
    } t_grad_word;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [ggs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [ggs_pkg::CFG_BITS-1:0]       i_cfg_data;

    ggs_in_if  sample_ch ();
    ggs_out_if grad_ch ();

    grid_gradient_stencil dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (sample_ch),
        .o_grad_ch   (grad_ch)
    );

    // Shadow of the block: size registers, two rows above, raster position
    logic [ggs_pkg::CFG_BITS-1:0] width_reg  = ggs_pkg::GRID_SIZE_RESET;
    logic [ggs_pkg::CFG_BITS-1:0] height_reg = ggs_pkg::GRID_SIZE_RESET;
    logic signed [15:0]  row_above     [MAX_W] = '{default: '0};
    logic signed [15:0]  row_two_above [MAX_W] = '{default: '0};
    int                  col_pos   = 0;
    int                  row_pos   = 0;
    bit                  flushing  = 0;
    int                  flush_col = 0;

    t_grad_word expected_grads[$];
    int         mismatch_count = 0;
    bit         in_idle  = 0;
    bit         out_idle = 0;
    int         stall_left = 0;

    // Clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        return 16'($urandom);
    endfunction

    // Effective size: below 2 acts as 2, above the maximum as the maximum
    function automatic int eff_size(logic [ggs_pkg::CFG_BITS-1:0] v, int maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    // One-sided at the ends, central inside, in half-sample units
    function automatic int line_slope(int prior_v, int mid, int next_v,
                                      bit at_first, bit at_last);
        if (at_first) return 2 * (next_v - mid);
        if (at_last) return 2 * (mid - prior_v);
        return next_v - prior_v;
    endfunction

    function automatic logic signed [ggs_pkg::GRAD_BITS-1:0] sat_grad(int g);
        if (g > GRAD_SAT) g = GRAD_SAT;
        if (g < -GRAD_SAT) g = -GRAD_SAT;
        return g[ggs_pkg::GRAD_BITS-1:0];
    endfunction

    task automatic store_grad(int gx, int gy, int c, int r, bit done);
        t_grad_word g;
        g.gx   = sat_grad(gx);
        g.gy   = sat_grad(gy);
        g.col  = c[9:0];
        g.row  = r[9:0];
        g.done = done;
        expected_grads.push_back(g);
    endtask

    // Advance the shadow by one accepted word and queue its gradient, if any
    task automatic predict_gradient(ggs_pkg::t_job_kind kind, logic signed [15:0] s);
        int w, h, c, r, left, mid, right, gx, gy;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        if (kind == ggs_pkg::JOB_FLUSH) begin
            if (!flushing) return;
            c     = flush_col;
            left  = (c > 0) ? row_above[c-1] : 0;
            mid   = row_above[c];
            right = (c + 1 < w) ? row_above[c+1] : 0;
            gx    = line_slope(left, mid, right, c == 0, c == w - 1);
            gy    = 2 * (mid - int'(row_two_above[c]));
            store_grad(gx, gy, c, h - 1, c == w - 1);
            if (c + 1 >= w) begin
                flushing  = 0;
                flush_col = 0;
            end else begin
                flush_col = c + 1;
            end
            return;
        end
        if (flushing) return;
        c = col_pos;
        r = row_pos;
        if (r > 0) begin
            // row_two_above[c-1] already holds row r-1 at column c-1
            left  = (c > 0) ? row_two_above[c-1] : 0;
            mid   = row_above[c];
            right = (c + 1 < w) ? row_above[c+1] : 0;
            gx    = line_slope(left, mid, right, c == 0, c == w - 1);
            gy    = line_slope(row_two_above[c], mid, s, r == 1, 1'b0);
            store_grad(gx, gy, c, r - 1, 1'b0);
        end
        row_two_above[c] = row_above[c];
        row_above[c]     = s;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r         = 0;
                flushing  = 1;
                flush_col = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic report(string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Send one word: optional gap, then hold valid until the handshake
    task automatic send_word(ggs_pkg::t_job_kind kind, logic [15:0] value);
        int gap;
        gap = pick_gap(in_idle);
        repeat (gap) begin
            @(negedge i_clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        sample_ch.valid        <= 1'b1;
        sample_ch.cmd          <= kind;
        sample_ch.sample_value <= value;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        predict_gradient(kind, value);
    endtask

    // Write one size register; any write restarts the frame
    task automatic write_reg(ggs_pkg::t_cfg_reg idx, logic [ggs_pkg::CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == ggs_pkg::REG_GRID_WIDTH) width_reg = value;
        else height_reg = value;
        col_pos   = 0;
        row_pos   = 0;
        flushing  = 0;
        flush_col = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic settle();
        int waited;
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        waited = 0;
        while (expected_grads.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_grads.size() != 0) begin
            report($sformatf("%0d gradient words never arrived", expected_grads.size()));
            expected_grads.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_field(int count);
        repeat (count) send_word(ggs_pkg::JOB_SAMPLE, pick_sample());
    endtask

    task automatic send_flushes(int count);
        repeat (count) send_word(ggs_pkg::JOB_FLUSH, pick_sample());
    endtask

    // Reset sizes (1024 x 1024): part of the first row gives nothing, stray flushes
    task automatic test_reset_size();
        in_idle  = 1;
        out_idle = 1;
        send_field(40);
        send_flushes(2);
        settle();
    endtask

    // Smallest fields, rail samples, clamped sizes, a 3 x 3 interior point
    task automatic test_directed();
        write_reg(ggs_pkg::REG_GRID_WIDTH, 11'd2);
        write_reg(ggs_pkg::REG_GRID_HEIGHT, 11'd2);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h7FFF);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h8000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h8000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h7FFF);
        send_flushes(2);
        // flush with no frame pending
        send_flushes(1);
        settle();
        // sizes 0 and 1 act as 2; a sample during the flush is dropped
        write_reg(ggs_pkg::REG_GRID_WIDTH, 11'd0);
        write_reg(ggs_pkg::REG_GRID_HEIGHT, 11'd1);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h8000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h0000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h7FFF);
        send_word(ggs_pkg::JOB_SAMPLE, 16'hFFFF);
        send_flushes(1);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h1234);
        send_flushes(1);
        settle();
        write_reg(ggs_pkg::REG_GRID_WIDTH, 11'd3);
        write_reg(ggs_pkg::REG_GRID_HEIGHT, 11'd3);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h0100);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h7FFF);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h0300);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h8000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h0000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h7FFF);
        send_word(ggs_pkg::JOB_SAMPLE, 16'hFF00);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h8000);
        send_word(ggs_pkg::JOB_SAMPLE, 16'h0080);
        send_flushes(3);
        settle();
    endtask

    // Sizes above the maximum and at zero, all register bits toggled
    task automatic test_size_limits();
        in_idle  = 1;
        out_idle = 0;
        write_reg(ggs_pkg::REG_GRID_WIDTH, 11'h7FF);
        write_reg(ggs_pkg::REG_GRID_HEIGHT, 11'h000);
        send_field(24);
        send_flushes(2);
        settle();
        in_idle  = 0;
        out_idle = 1;
        write_reg(ggs_pkg::REG_GRID_WIDTH, 11'h001);
        write_reg(ggs_pkg::REG_GRID_HEIGHT, 11'h7FF);
        send_field(64);
        send_flushes(2);
        settle();
    endtask

    // Mostly complete small fields; some aborted, some with dropped words
    task automatic test_random_frames();
        int sent, w, h, n, kind, reps;
        sent = 0;
        while (sent < 490) begin
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            kind     = $urandom_range(0, 9);
            if ($urandom_range(0, 4) != 0)
                write_reg(ggs_pkg::REG_GRID_WIDTH, 11'($urandom_range(2, 9)));
            write_reg(ggs_pkg::REG_GRID_HEIGHT, 11'($urandom_range(2, 6)));
            w    = eff_size(width_reg, MAX_W);
            h    = eff_size(height_reg, MAX_H);
            reps = (kind == 1) ? 2 : 1;
            repeat (reps) begin
                n = (kind == 0) ? $urandom_range(1, w * h - 1) : w * h;
                send_field(n);
                sent += n;
                if (n == w * h) begin
                    repeat (w) begin
                        // sample during the flush is ignored
                        if (kind >= 7 && $urandom_range(0, 2) == 0)
                            send_word(ggs_pkg::JOB_SAMPLE, pick_sample());
                        send_word(ggs_pkg::JOB_FLUSH, pick_sample());
                    end
                    sent += w;
                    if (kind >= 7) send_flushes($urandom_range(1, 3));
                end
            end
            settle();
        end
    endtask

    // Output stalls: random runs of low ready
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            grad_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            grad_ch.ready <= 1'b1;
            stall_left = pick_gap(out_idle);
        end
    end

    // Compare each accepted gradient word with the oldest expectation
    always @(posedge i_clk) begin : check_grads
        t_grad_word want;
        if (i_rst_n && grad_ch.valid && grad_ch.ready) begin
            if (expected_grads.size() == 0) begin
                report($sformatf("unexpected word at col %0d row %0d",
                                 grad_ch.point_col, grad_ch.point_row));
            end else begin
                want = expected_grads.pop_front();
                if (grad_ch.grad_x !== want.gx)
                    report($sformatf("grad_x at (%0d,%0d): got %0d want %0d",
                                     want.col, want.row, grad_ch.grad_x, want.gx));
                if (grad_ch.grad_y !== want.gy)
                    report($sformatf("grad_y at (%0d,%0d): got %0d want %0d",
                                     want.col, want.row, grad_ch.grad_y, want.gy));
                if (grad_ch.point_col !== want.col)
                    report($sformatf("point_col: got %0d want %0d",
                                     grad_ch.point_col, want.col));
                if (grad_ch.point_row !== want.row)
                    report($sformatf("point_row: got %0d want %0d",
                                     grad_ch.point_row, want.row));
                if (grad_ch.frame_done !== want.done)
                    report($sformatf("frame_done at (%0d,%0d): got %0b want %0b",
                                     want.col, want.row, grad_ch.frame_done, want.done));
            end
        end
    end

    // Run the tests in turn
    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = ggs_pkg::REG_GRID_WIDTH;
        i_cfg_data             = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.cmd          = ggs_pkg::JOB_SAMPLE;
        sample_ch.sample_value = '0;
        grad_ch.ready          = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_size();
        test_directed();
        test_size_limits();
        test_random_frames();
        settle();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
